[rtl/core/vfl_pkg.sv]
// ----------------------------------------------------------------------------
// vfl_pkg: shared types and constants of the velocity feedback low-pass
// Field widths, register indexes, reset value, channel codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package vfl_pkg;

    // Field widths
    localparam int VEL_W = 32;
    localparam int TAU_W = 24;
    localparam int DT_W  = 16;

    // Divisor tau + dt needs one bit more than tau
    localparam int DIV_W = TAU_W + 1;

    // Configuration register indexes
    localparam logic REG_TRANSLATION_TAU = 1'b0;
    localparam logic REG_YAW_TAU         = 1'b1;

    // Reset value of both time constants
    localparam logic [TAU_W-1:0] TAU_RESET = 24'd20000;

    // Channel codes
    localparam logic [1:0] CH_VX = 2'd0;
    localparam logic [1:0] CH_VY = 2'd1;
    localparam logic [1:0] CH_WZ = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_DIV_Y,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

[rtl/core/velocity_feedback_lowpass.sv]
// ----------------------------------------------------------------------------
// velocity_feedback_lowpass: variable-step first-order low-pass filter
// Smooths vx, vy and yaw rate with alpha = dt/(tau+dt) from a serial divider
// and one shared multiplier, under a small sequencer.
//
//  Channel   Dir  Handshake                   Payload
//  s_axis    in   s_axis_tvalid/tready        tdata vx,vy,wz,dt; tuser ok flags
//  m_axis    out  m_axis_tvalid/tready        tdata vx,vy,wz; tuser valid flags
//  cfg       in   i_cfg_we                    i_cfg_index, i_cfg_data
//
//  Sequence: each word takes two serial divisions on the shared divider,
//  translation alpha then yaw alpha, then a multiply and an add per channel
//  on the shared multiplier, before the result goes to the output register.
//  s_axis_tready is high only while the sequencer is idle.
//  A result waits in the output register; a stalled m_axis holds the
//  sequencer before it loads the next result.
//  Reset is synchronous, active low; it clears filter state and ready flags.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_feedback_lowpass
    import vfl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Input words
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [111:0]  s_axis_tdata,   // vx_raw, vy_raw, wz_raw, dt_us
    input  wire logic [1:0]    s_axis_tuser,   // wheel_ok, gyro_ok
    // Result words
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [95:0]        m_axis_tdata,   // vx_filtered, vy_filtered, wz_filtered
    output logic [2:0]         m_axis_tuser,   // wheel_valid_out, gyro_valid_out, all_valid
    // Configuration writes
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [23:0]   i_cfg_data
);

    localparam int PROD_W = FRAC_BITS + 1 + VEL_W + 1;

    t_state r_state, n_state;

    logic [TAU_W-1:0]           r_tau_t;
    logic [TAU_W-1:0]           r_tau_y;
    logic signed [VEL_W-1:0]    r_raw [3];
    logic signed [VEL_W-1:0]    r_val [3];
    logic [DT_W-1:0]            r_dt;
    logic                       r_wheel;
    logic                       r_gyro;
    logic                       r_ready_t;
    logic                       r_ready_y;
    logic [FRAC_BITS-1:0]       r_alpha_t;
    logic [FRAC_BITS-1:0]       r_alpha_y;
    logic [1:0]                 r_ch;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    logic [95:0]                r_out_data;
    logic [2:0]                 r_out_user;

    logic                       in_accept;
    logic                       out_free;
    logic                       div_start;
    logic                       div_done;
    logic [FRAC_BITS-1:0]       div_alpha;
    logic [DT_W-1:0]            div_dt;
    logic [TAU_W-1:0]           div_tau;

    logic signed [VEL_W:0]      diff;
    logic [FRAC_BITS-1:0]       alpha_sel;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [VEL_W-1:0]    val_new;
    logic                       ch_ok;
    logic                       ch_ready;
    logic                       ch_tau_zero;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau_t <= TAU_RESET;
            r_tau_y <= TAU_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TRANSLATION_TAU: r_tau_t <= i_cfg_data;
                REG_YAW_TAU:         r_tau_y <= i_cfg_data;
                default:             ;
            endcase
        end
    end

    // Shared divider: translation alpha first, then yaw alpha
    assign div_start = in_accept || (r_state == ST_DIV_T && div_done);
    assign div_dt    = (r_state == ST_IDLE) ? s_axis_tdata[111:96] : r_dt;
    assign div_tau   = (r_state == ST_IDLE) ? r_tau_t : r_tau_y;

    vfl_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dt    (div_dt),
        .i_tau   (div_tau),
        .o_done  (div_done),
        .o_alpha (div_alpha)
    );

    // Per-channel selection for the shared multiplier and adder
    always_comb begin
        ch_ok       = (r_ch == CH_WZ) ? r_gyro : r_wheel;
        ch_ready    = (r_ch == CH_WZ) ? r_ready_y : r_ready_t;
        ch_tau_zero = (r_ch == CH_WZ) ? (r_tau_y == '0) : (r_tau_t == '0);
        alpha_sel   = (r_ch == CH_WZ) ? r_alpha_y : r_alpha_t;
        diff        = (VEL_W+1)'(r_raw[r_ch]) - (VEL_W+1)'(r_val[r_ch]);
        prod_sh     = r_prod >>> FRAC_BITS;
        if (!ch_ok) begin
            val_new = r_val[r_ch];
        end else if (!ch_ready || r_dt == '0 || ch_tau_zero) begin
            val_new = r_raw[r_ch];
        end else begin
            val_new = r_val[r_ch] + prod_sh[VEL_W-1:0];
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_accept) n_state = ST_DIV_T;
            ST_DIV_T: if (div_done) n_state = ST_DIV_Y;
            ST_DIV_Y: if (div_done) n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = (r_ch == CH_WZ) ? ST_OUT : ST_MUL;
            ST_OUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_raw[CH_VX] <= s_axis_tdata[31:0];
            r_raw[CH_VY] <= s_axis_tdata[63:32];
            r_raw[CH_WZ] <= s_axis_tdata[95:64];
            r_dt         <= s_axis_tdata[111:96];
            r_wheel      <= s_axis_tuser[0];
            r_gyro       <= s_axis_tuser[1];
        end
    end

    // Hold alphas, step the channel, run multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= CH_VX;
        end else begin
            if (r_state == ST_DIV_Y && div_done) begin
                r_ch <= CH_VX;
            end else if (r_state == ST_ADD && r_ch != CH_WZ) begin
                r_ch <= r_ch + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV_T && div_done) begin
            r_alpha_t <= div_alpha;
        end
        if (r_state == ST_DIV_Y && div_done) begin
            r_alpha_y <= div_alpha;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'($signed({1'b0, alpha_sel}) * diff);
        end
    end

    // Filter state and seeded flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val[CH_VX] <= '0;
            r_val[CH_VY] <= '0;
            r_val[CH_WZ] <= '0;
            r_ready_t    <= 1'b0;
            r_ready_y    <= 1'b0;
        end else begin
            if (r_state == ST_ADD) begin
                r_val[r_ch] <= val_new;
            end
            if (r_state == ST_OUT && out_free) begin
                r_ready_t <= r_wheel;
                r_ready_y <= r_gyro;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= {r_val[CH_WZ], r_val[CH_VY], r_val[CH_VX]};
            r_out_user <= {r_wheel && r_gyro, r_gyro, r_wheel};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Checks
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_DIV_T)
        else $error("accepted word did not start the division");

    a_add_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ADD |-> $past(r_state) == ST_MUL)
        else $error("add step without a multiply step");

    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ch == CH_VX || r_ch == CH_VY || r_ch == CH_WZ)
        else $error("channel index out of range");

    a_invalid_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free && !r_wheel) |=> !r_ready_t)
        else $error("invalid wheel word left the translation channel seeded");

    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

[rtl/core/vfl_divider.sv]
// ----------------------------------------------------------------------------
// vfl_divider: serial restoring divider for the smoothing factor
// Computes alpha = floor((dt << FRAC_BITS) / (tau + dt)), one quotient bit
// per cycle. Valid only for tau > 0; the caller ignores the result otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module vfl_divider
    import vfl_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [DT_W-1:0]      i_dt,
    input  wire logic [TAU_W-1:0]     i_tau,
    output logic                      o_done,
    output logic [FRAC_BITS-1:0]      o_alpha
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_div;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_done;

    logic [DIV_W:0]       rem_shift;
    logic [DIV_W:0]       rem_try;

    // Trial subtract of the divisor from the doubled remainder
    assign rem_shift = {r_rem, 1'b0};
    assign rem_try   = rem_shift - {1'b0, r_div};

    // Control: bit counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(FRAC_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then shift in one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIV_W'(i_dt);
            r_div <= DIV_W'(i_tau) + DIV_W'(i_dt);
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            if (!rem_try[DIV_W]) begin
                r_rem <= rem_try[DIV_W-1:0];
                r_quo <= {r_quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift[DIV_W-1:0];
                r_quo <= {r_quo[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done  = r_done;
    assign o_alpha = r_quo;

endmodule

`default_nettype wire
